FILE: src/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; expects clk_i and rst_ni in the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define DMAS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising edge, reset included
`define DMAS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/dmas_pkg.sv
// widths, register codes and reset values of the deadband moving average scaler
// no dependencies
`default_nettype none

package dmas_pkg;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned ENTRY_W   = 12;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned GAIN_W    = 10;
  localparam int unsigned SMOOTH_W  = 15;
  localparam int unsigned GAIN_FRAC = 8;
  localparam int unsigned MAP_SHIFT = 10;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ENTRY_W-1:0] ENTRY_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_GAIN = 2'd3;

  localparam logic [CFG_W-1:0]  MAP_LOW_RST   = 12'd0;
  localparam logic [CFG_W-1:0]  MAP_HIGH_RST  = 12'd1024;
  localparam logic [CFG_W-1:0]  DEADBAND_RST  = 12'd1;
  localparam logic [GAIN_W-1:0] RAMP_GAIN_RST = 10'd614;

endpackage

`default_nettype wire

FILE: src/dmas_ring.sv
// ring storage of the scaled samples: one write port, one registered read port
// depends on dmas_pkg
`default_nettype none

module dmas_ring #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [ADDR_W-1:0]           waddr_i,
  input  wire logic [dmas_pkg::ENTRY_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0]           raddr_i,
  output logic      [dmas_pkg::ENTRY_W-1:0] rdata_o
);
  import dmas_pkg::*;

  logic [ENTRY_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/dmas_mul.sv
// shared multiplier with a registered product
// depends on dmas_pkg only through the top level that sizes it
`default_nettype none

module dmas_mul #(
  parameter int unsigned A_W = 16,
  parameter int unsigned B_W = 20
) (
  input  wire logic               clk_i,
  input  wire logic [A_W-1:0]     a_i,
  input  wire logic [B_W-1:0]     b_i,
  output logic      [A_W+B_W-1:0] prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= {{B_W{1'b0}}, a_i} * {{A_W{1'b0}}, b_i};
  end

endmodule

`default_nettype wire

FILE: src/deadband_moving_average_scaler.sv
// deadband moving average scaler: top level with sequencer and config registers
// depends on dmas_pkg, dmas_ring, dmas_mul and assert_macros.svh
//
// Usage: one 10-bit sample word comes in on the input valid/ready channel,
// one result word (smoothed, held_sample) leaves on the output channel.
// Configuration is to be written through cfg_we_i / cfg_idx_i / cfg_data_i
// only with no word in flight (not enforced by the block); writes take effect at once.
// Each word walks a six-state sequencer around one shared multiplier:
// ring read, gain multiply, mean by reciprocal multiply, range map multiply,
// output load. The result word is loaded into the output register in the final
// state, and the next input is taken only once the sequencer is back in idle, so
// no new word enters while one is in flight; the multiplier is used three times per word.
// in_ready_o is high only in the idle state. A new word may be accepted
// while the previous result still waits; if the receiver stalls, the next
// result holds in the final state until the output register is free.
// Reset clears the config registers to their defaults, the ring pointer,
// the running total and the primed flag; no clearing pass is needed, the
// first word after reset stands in for every ring entry until overwritten.
`default_nettype none
`include "assert_macros.svh"

module deadband_moving_average_scaler #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dmas_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dmas_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [dmas_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [dmas_pkg::SMOOTH_W-1:0]  smoothed_o,
  output logic      [dmas_pkg::ENTRY_W-1:0]   held_sample_o
);
  import dmas_pkg::*;

  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam longint unsigned TOTAL_MAX = longint'(DEPTH) * 4095;
  localparam int unsigned SUM_W     = $clog2(TOTAL_MAX + 1);
  // mean = (total * RECIP) >> DIV_K is exact for every total up to TOTAL_MAX
  localparam int unsigned DIV_K     = SUM_W + $clog2(DEPTH);
  localparam longint unsigned RECIP = ((64'd1 << DIV_K) + DEPTH - 1) / DEPTH;
  localparam int unsigned RECIP_W   = DIV_K;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_GAIN,
    ST_MEAN,
    ST_SPAN,
    ST_OUT
  } state_e;

  state_e state_q;

  logic [CFG_W-1:0]    map_low_q, map_high_q, deadband_q;
  logic [GAIN_W-1:0]   ramp_gain_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [ENTRY_W-1:0]  prime_val_q;
  logic [ENTRY_W-1:0]  held_q;
  logic [ENTRY_W-1:0]  mean_q;
  logic [ADDR_W-1:0]   write_slot_q;
  logic [SUM_W-1:0]    total_q;
  logic                primed_q, written_q, wrapped_q;
  logic                out_valid_q;
  logic [SMOOTH_W-1:0] smoothed_q;
  logic [ENTRY_W-1:0]  held_out_q;

  logic                accept;
  logic [ADDR_W-1:0]   next_slot;
  logic [ADDR_W-1:0]   raddr;
  logic [ENTRY_W-1:0]  rdata;
  logic [ENTRY_W-1:0]  last, old_entry, sample_ext, diff, held;
  logic [ENTRY_W-1:0]  scaled;
  logic [SUM_W-1:0]    total_d;
  logic [CFG_W-1:0]    span;
  logic                ring_we;
  logic [SUM_W-1:0]    mul_a;
  logic [RECIP_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod;
  logic                out_free;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign next_slot  = (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + 1'b1;
  assign raddr      = (state_q == ST_IDLE) ? write_slot_q : next_slot;
  assign out_free   = !out_valid_q || out_ready_i;

  // entries not yet overwritten since the first word still hold that word
  assign last       = written_q ? rdata : prime_val_q;
  assign old_entry  = wrapped_q ? rdata : prime_val_q;
  assign sample_ext = ENTRY_W'(sample_q);
  assign diff       = (sample_ext >= last) ? sample_ext - last : last - sample_ext;
  assign held       = (diff <= deadband_q) ? last : sample_ext;

  assign scaled  = (|prod[PROD_W-1:GAIN_FRAC+ENTRY_W]) ? ENTRY_MAX
                                                       : prod[GAIN_FRAC +: ENTRY_W];
  assign total_d = total_q - SUM_W'(old_entry) + SUM_W'(scaled);
  assign span    = (map_high_q > map_low_q) ? map_high_q - map_low_q : '0;
  assign ring_we = (state_q == ST_GAIN);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_LAST: begin
        mul_a = SUM_W'(held);
        mul_b = RECIP_W'(ramp_gain_q);
      end
      ST_MEAN: begin
        mul_a = total_q;
        mul_b = RECIP_W'(RECIP);
      end
      ST_SPAN: begin
        mul_a = SUM_W'(prod[DIV_K +: ENTRY_W]);
        mul_b = RECIP_W'(span);
      end
      // keep the range product steady while the result waits
      ST_OUT: begin
        mul_a = SUM_W'(mean_q);
        mul_b = RECIP_W'(span);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dmas_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (next_slot),
    .wdata_i (scaled),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  dmas_mul #(
    .A_W (SUM_W),
    .B_W (RECIP_W)
  ) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_low_q   <= MAP_LOW_RST;
      map_high_q  <= MAP_HIGH_RST;
      deadband_q  <= DEADBAND_RST;
      ramp_gain_q <= RAMP_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAP_LOW:   map_low_q   <= cfg_data_i;
        REG_MAP_HIGH:  map_high_q  <= cfg_data_i;
        REG_DEADBAND:  deadband_q  <= cfg_data_i;
        REG_RAMP_GAIN: ramp_gain_q <= cfg_data_i[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
      if (!primed_q) begin
        prime_val_q <= ENTRY_W'(sample_i);
      end
    end
    if (state_q == ST_LAST) begin
      held_q <= held;
    end
    if (state_q == ST_SPAN) begin
      mean_q <= prod[DIV_K +: ENTRY_W];
    end
    if (state_q == ST_OUT && out_free) begin
      smoothed_q <= SMOOTH_W'(map_low_q) +
                    SMOOTH_W'(prod[MAP_SHIFT +: SMOOTH_W-1]);
      held_out_q <= held_q;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      write_slot_q <= '0;
      total_q      <= '0;
      primed_q     <= 1'b0;
      written_q    <= 1'b0;
      wrapped_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (!primed_q) begin
              primed_q <= 1'b1;
              total_q  <= SUM_W'(sample_i) * SUM_W'(DEPTH);
            end
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          state_q <= ST_GAIN;
        end
        ST_GAIN: begin
          total_q      <= total_d;
          write_slot_q <= next_slot;
          written_q    <= 1'b1;
          if (next_slot == '0) begin
            wrapped_q <= 1'b1;
          end
          state_q <= ST_MEAN;
        end
        ST_MEAN: begin
          state_q <= ST_SPAN;
        end
        ST_SPAN: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign smoothed_o    = smoothed_q;
  assign held_sample_o = held_out_q;

  `DMAS_ASSERT(a_wrap_after_write, wrapped_q |-> written_q, "ring wrapped before any write")
  `DMAS_ASSERT(a_primed_on_accept, accept |=> primed_q, "word accepted but ring not primed")
  `DMAS_ASSERT(a_total_bound, total_q <= SUM_W'(TOTAL_MAX), "running total out of range")
  `DMAS_ASSERT_ALWAYS(a_ready_idle, in_ready_o |-> (state_q != ST_OUT), "ready while busy")

endmodule

`default_nettype wire
